@@ sv/cbt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbt_pkg
// Shared types and constants of the colour blob tracker.
// ----------------------------------------------------------------------------
package cbt_pkg;

	localparam int MAX_WIDTH   = 2048;
	localparam int MAX_HEIGHT  = 2048;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ROW_W       = $clog2(MAX_HEIGHT);
	localparam int CNT_W       = 23;
	localparam int SUM_W       = 34;
	localparam int DEN_W       = 23;
	localparam logic [CNT_W-1:0] COUNT_LIMIT = '1;

	localparam logic [7:0] SAT_LOW = 8'd120;
	localparam logic [7:0] VAL_LOW = 8'd70;
	localparam logic [20:0] SSCALE_BASE = 21'd2088960;
	localparam logic [20:0] HSCALE_BASE = 21'd1474560;
	localparam logic [28:0] HALF_LSB = 29'd2048;

	localparam logic [1:0] FUNC_PIXEL  = 2'd0;
	localparam logic [1:0] FUNC_MANUAL = 2'd1;
	localparam logic [1:0] FUNC_RANGE  = 2'd2;

	localparam logic [1:0] MODE_NONE  = 2'd0;
	localparam logic [1:0] MODE_BLUE  = 2'd1;
	localparam logic [1:0] MODE_GREEN = 2'd2;
	localparam logic [1:0] MODE_RED   = 2'd3;

	localparam logic [2:0] REG_TARGET_MODE = 3'd0;
	localparam logic [2:0] REG_FRAME_WIDTH = 3'd1;
	localparam logic [2:0] REG_FRAME_HEIGHT = 3'd2;
	localparam logic [2:0] REG_DEADZONE    = 3'd3;
	localparam logic [2:0] REG_YAW_GAIN    = 3'd4;
	localparam logic [2:0] REG_PITCH_GAIN  = 3'd5;
	localparam logic [2:0] REG_MIN_COUNT   = 3'd6;

	typedef struct packed {
		logic [1:0]  target_mode;
		logic [11:0] frame_width;
		logic [11:0] frame_height;
		logic [10:0] deadzone_pixels;
		logic [19:0] yaw_gain;
		logic [19:0] pitch_gain;
		logic [22:0] min_count;
	} cfg_t;

	typedef enum logic [1:0] {
		JOB_FRAME,
		JOB_MANUAL,
		JOB_RANGE
	} job_kind_t;

	typedef struct packed {
		job_kind_t        kind;
		logic [SUM_W-1:0] a;
		logic [SUM_W-1:0] b;
		logic [CNT_W-1:0] cnt;
	} job_t;

	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		logic signed [34:0] hi;
		logic signed [34:0] lo;
		hi = 35'sh0_7FFF_FFFF;
		lo = -35'sh0_8000_0000;
		if (v > hi)
			return 32'sh7FFF_FFFF;
		else if (v < lo)
			return 32'sh8000_0000;
		else
			return v[31:0];
	endfunction

endpackage

@@ sv/cbt_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbt_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cbt_pkg::SUM_W-1:0]   num,
	input  logic [cbt_pkg::DEN_W-1:0]   den,
	output logic                        done,
	output logic [cbt_pkg::SUM_W-1:0]   quot
);

	localparam int STEP_W = $clog2(cbt_pkg::SUM_W + 1);

	logic [STEP_W-1:0]          cnt_q;
	logic                       done_q;
	logic [cbt_pkg::SUM_W-1:0]  n_q;
	logic [cbt_pkg::DEN_W-1:0]  d_q;
	logic [cbt_pkg::DEN_W-1:0]  rem_q;
	logic [cbt_pkg::DEN_W:0]    trial;
	logic [cbt_pkg::DEN_W:0]    sub;
	logic                       ge;

	assign trial = {rem_q, n_q[cbt_pkg::SUM_W-1]};
	assign ge    = trial >= {1'b0, d_q};
	assign sub   = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= STEP_W'(cbt_pkg::SUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			d_q   <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			n_q   <= {n_q[cbt_pkg::SUM_W-2:0], ge};
			rem_q <= ge ? sub[cbt_pkg::DEN_W-1:0] : trial[cbt_pkg::DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = n_q;

endmodule

@@ sv/cbt_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbt_front
// Accepts requests, tests pixels against the colour window, accumulates
// the mask and queues frame, manual and range jobs.
// ----------------------------------------------------------------------------
module cbt_front (
	input  logic                clk,
	input  logic                arst_n,
	input  cbt_pkg::cfg_t       cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          func,
	input  logic [7:0]          blue,
	input  logic [7:0]          green,
	input  logic [7:0]          red,
	input  logic                end_of_frame,
	input  logic signed [31:0]  manual_yaw,
	input  logic signed [31:0]  manual_pitch,
	input  logic [15:0]         range_mm,
	input  logic                range_ok,
	input  logic [15:0]         range_min_mm,
	input  logic [15:0]         range_max_mm,
	input  logic                q_full,
	output logic                q_push,
	output cbt_pkg::job_t       q_job
);

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_MUL,
		F_EVAL
	} fstate_t;

	fstate_t                    state_q;
	logic                       accept;
	logic [7:0]                 vmax;
	logic [7:0]                 vmin;
	logic [7:0]                 diff;
	logic signed [11:0]         raw;
	logic                       try_div;
	logic                       s_done;
	logic                       h_done;
	logic [cbt_pkg::SUM_W-1:0]  s_quot;
	logic [cbt_pkg::SUM_W-1:0]  h_quot;
	logic [cbt_pkg::SUM_W-1:0]  s_num;
	logic [cbt_pkg::SUM_W-1:0]  h_num;
	logic [cbt_pkg::DEN_W-1:0]  s_den;
	logic [cbt_pkg::DEN_W-1:0]  h_den;

	logic [7:0]                 diff_s1;
	logic signed [11:0]         raw_s1;
	logic                       try_s1;
	logic                       eof_s1;
	logic [28:0]                sprod_s2;
	logic signed [29:0]         hprod_s2;

	logic [cbt_pkg::COL_W-1:0]  col_q;
	logic [cbt_pkg::ROW_W-1:0]  row_q;
	logic [cbt_pkg::CNT_W-1:0]  cnt_q;
	logic [cbt_pkg::SUM_W-1:0]  sumx_q;
	logic [cbt_pkg::SUM_W-1:0]  sumy_q;

	logic [29:0]                s_round;
	logic signed [29:0]         h_round;
	logic signed [17:0]         h_raw;
	logic signed [17:0]         h_val;
	logic                       win;
	logic                       match;
	logic [cbt_pkg::CNT_W-1:0]  cnt_n;
	logic [cbt_pkg::SUM_W-1:0]  sumx_n;
	logic [cbt_pkg::SUM_W-1:0]  sumy_n;
	logic [cbt_pkg::COL_W:0]    col_inc;
	logic                       emit;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != F_IDLE) || q_full;

	always_comb begin
		vmax = blue;
		vmin = blue;
		if (green > vmax) vmax = green;
		if (red > vmax)   vmax = red;
		if (green < vmin) vmin = green;
		if (red < vmin)   vmin = red;
		diff = vmax - vmin;
		if (vmax == red)
			raw = $signed({4'd0, green}) - $signed({4'd0, blue});
		else if (vmax == green)
			raw = $signed({4'd0, blue}) - $signed({4'd0, red})
				+ $signed({3'd0, diff, 1'b0});
		else
			raw = $signed({4'd0, red}) - $signed({4'd0, green})
				+ $signed({2'd0, diff, 2'b0});
	end

	assign try_div = (cfg.target_mode != cbt_pkg::MODE_NONE)
		&& (cnt_q != cbt_pkg::COUNT_LIMIT) && (vmax >= cbt_pkg::VAL_LOW)
		&& (diff != 8'd0);

	assign s_num = cbt_pkg::SUM_W'(cbt_pkg::SSCALE_BASE) + cbt_pkg::SUM_W'(vmax);
	assign s_den = cbt_pkg::DEN_W'({vmax, 1'b0});
	assign h_num = cbt_pkg::SUM_W'(cbt_pkg::HSCALE_BASE) + cbt_pkg::SUM_W'(diff) * 6;
	assign h_den = cbt_pkg::DEN_W'(diff) * cbt_pkg::DEN_W'(12);

	cbt_div u_sdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && func == cbt_pkg::FUNC_PIXEL && try_div),
		.num    (s_num),
		.den    (s_den),
		.done   (s_done),
		.quot   (s_quot)
	);

	cbt_div u_hdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && func == cbt_pkg::FUNC_PIXEL && try_div),
		.num    (h_num),
		.den    (h_den),
		.done   (h_done),
		.quot   (h_quot)
	);

	// saturation and hue from the scaled products
	assign s_round = {1'b0, sprod_s2} + 30'(cbt_pkg::HALF_LSB);
	assign h_round = hprod_s2 + 30'sd2048;
	assign h_raw   = 18'(h_round >>> 12);
	assign h_val   = (h_raw < 0) ? h_raw + 18'sd180 : h_raw;

	always_comb begin
		unique case (cfg.target_mode)
			cbt_pkg::MODE_BLUE:  win = h_val >= 100 && h_val <= 140;
			cbt_pkg::MODE_GREEN: win = h_val >= 40 && h_val <= 80;
			cbt_pkg::MODE_RED:   win = (h_val >= 0 && h_val <= 10)
				|| (h_val >= 170 && h_val <= 180);
			default:             win = 1'b0;
		endcase
	end

	assign match  = try_s1 && (s_round >= 30'(int'(cbt_pkg::SAT_LOW) * 4096)) && win;
	assign cnt_n  = cnt_q + cbt_pkg::CNT_W'(match);
	assign sumx_n = match ? sumx_q + cbt_pkg::SUM_W'(col_q) : sumx_q;
	assign sumy_n = match ? sumy_q + cbt_pkg::SUM_W'(row_q) : sumy_q;
	assign col_inc = {1'b0, col_q} + 1'b1;
	assign emit   = (cfg.target_mode != cbt_pkg::MODE_NONE)
		&& (cnt_n > cfg.min_count);

	always_comb begin
		q_push    = 1'b0;
		q_job     = '0;
		q_job.kind = cbt_pkg::JOB_FRAME;
		if (state_q == F_EVAL) begin
			q_push    = eof_s1 && emit;
			q_job.a   = sumx_n;
			q_job.b   = sumy_n;
			q_job.cnt = cnt_n;
		end else if (accept && func == cbt_pkg::FUNC_MANUAL) begin
			q_push     = cfg.target_mode == cbt_pkg::MODE_NONE;
			q_job.kind = cbt_pkg::JOB_MANUAL;
			q_job.a    = cbt_pkg::SUM_W'(unsigned'(manual_yaw));
			q_job.b    = cbt_pkg::SUM_W'(unsigned'(manual_pitch));
		end else if (accept && func == cbt_pkg::FUNC_RANGE) begin
			q_push     = range_ok && range_mm >= range_min_mm && range_mm <= range_max_mm;
			q_job.kind = cbt_pkg::JOB_RANGE;
			q_job.a    = cbt_pkg::SUM_W'(range_mm);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			cnt_q   <= '0;
			sumx_q  <= '0;
			sumy_q  <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept && func == cbt_pkg::FUNC_PIXEL)
						state_q <= try_div ? F_DIV : F_EVAL;
				end
				F_DIV: begin
					if (s_done && h_done)
						state_q <= F_MUL;
				end
				F_MUL: begin
					state_q <= F_EVAL;
				end
				F_EVAL: begin
					state_q <= F_IDLE;
					if (col_inc >= cfg.frame_width
							|| col_inc >= (cbt_pkg::COL_W+1)'(cbt_pkg::MAX_WIDTH)) begin
						col_q <= '0;
						if (row_q != cbt_pkg::ROW_W'(cbt_pkg::MAX_HEIGHT - 1))
							row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_inc[cbt_pkg::COL_W-1:0];
					end
					cnt_q  <= cnt_n;
					sumx_q <= sumx_n;
					sumy_q <= sumy_n;
					if (eof_s1) begin
						col_q  <= '0;
						row_q  <= '0;
						cnt_q  <= '0;
						sumx_q <= '0;
						sumy_q <= '0;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && func == cbt_pkg::FUNC_PIXEL) begin
			diff_s1 <= diff;
			raw_s1  <= raw;
			try_s1  <= try_div;
			eof_s1  <= end_of_frame;
		end
		if (state_q == F_DIV) begin
			sprod_s2 <= 29'(diff_s1) * 29'(s_quot[19:0]);
			hprod_s2 <= 30'(raw_s1) * $signed({13'd0, h_quot[16:0]});
		end
	end

endmodule

@@ sv/cbt_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbt_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module cbt_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cbt_pkg::job_t push_job,
	input  logic          pop,
	output cbt_pkg::job_t head,
	output logic          empty,
	output logic          full
);

	cbt_pkg::job_t mem_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    fill_q;

	assign empty = fill_q == 2'd0;
	assign full  = fill_q == 2'd2;
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fill_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= push_job;
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop)) else $error("job queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("job queue underflow");
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 2'd2) else $error("job queue fill out of range");
`endif

endmodule

@@ sv/cbt_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbt_back
// Carries out queued jobs: centroid division, deadzone, gain and
// saturating integration of the commands, manual and range loads, and the result register.
// ----------------------------------------------------------------------------
module cbt_back (
	input  logic                clk,
	input  logic                arst_n,
	input  cbt_pkg::cfg_t       cfg,
	input  cbt_pkg::job_t       head,
	input  logic                q_empty,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  yaw_command,
	output logic signed [31:0]  pitch_command,
	output logic [15:0]         target_range_mm,
	output logic                range_valid
);

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_MUL,
		B_SAT
	} bstate_t;

	bstate_t                    state_q;
	logic                       start;
	logic                       x_done;
	logic                       y_done;
	logic [cbt_pkg::SUM_W-1:0]  x_quot;
	logic [cbt_pkg::SUM_W-1:0]  y_quot;
	logic signed [31:0]         yaw_q;
	logic signed [31:0]         pitch_q;
	logic [15:0]                range_q;
	logic                       seen_q;
	logic                       out_valid_q;
	logic signed [12:0]         ex;
	logic signed [12:0]         ey;
	logic [12:0]                ex_mag;
	logic [12:0]                ey_mag;
	logic signed [12:0]         ex_s1;
	logic signed [12:0]         ey_s1;
	logic signed [33:0]         yprod_s2;
	logic signed [33:0]         pprod_s2;
	logic signed [34:0]         yaw_sum;
	logic signed [34:0]         pitch_sum;
	logic                       load;

	assign q_pop = (state_q == B_IDLE) && !q_empty;
	assign start = q_pop && head.kind == cbt_pkg::JOB_FRAME;
	assign load  = (state_q == B_SAT) && (!out_valid_q || !out_stall);

	cbt_div u_xdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.num    (head.a),
		.den    (head.cnt),
		.done   (x_done),
		.quot   (x_quot)
	);

	cbt_div u_ydiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.num    (head.b),
		.den    (head.cnt),
		.done   (y_done),
		.quot   (y_quot)
	);

	assign ex = $signed({2'b0, cfg.frame_width[11:1]}) - $signed({2'b0, x_quot[10:0]});
	assign ey = $signed({2'b0, cfg.frame_height[11:1]}) - $signed({2'b0, y_quot[10:0]});
	assign ex_mag = ex[12] ? 13'(-ex) : 13'(ex);
	assign ey_mag = ey[12] ? 13'(-ey) : 13'(ey);

	assign yaw_sum   = 35'(yaw_q) + 35'(yprod_s2);
	assign pitch_sum = 35'(pitch_q) - 35'(pprod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			yaw_q       <= '0;
			pitch_q     <= '0;
			range_q     <= '0;
			seen_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (q_pop) begin
						unique case (head.kind)
							cbt_pkg::JOB_MANUAL: begin
								yaw_q   <= head.a[31:0];
								pitch_q <= head.b[31:0];
							end
							cbt_pkg::JOB_RANGE: begin
								range_q <= head.a[15:0];
								seen_q  <= 1'b1;
							end
							default: state_q <= B_DIV;
						endcase
					end
				end
				B_DIV: begin
					if (x_done && y_done)
						state_q <= B_MUL;
				end
				B_MUL: begin
					state_q <= B_SAT;
				end
				B_SAT: begin
					if (load) begin
						yaw_q       <= cbt_pkg::sat32(yaw_sum);
						pitch_q     <= cbt_pkg::sat32(pitch_sum);
						out_valid_q <= 1'b1;
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_DIV) begin
			ex_s1 <= (ex_mag < {2'b0, cfg.deadzone_pixels}) ? '0 : ex;
			ey_s1 <= (ey_mag < {2'b0, cfg.deadzone_pixels}) ? '0 : ey;
		end
		if (state_q == B_MUL) begin
			yprod_s2 <= 34'(ex_s1) * $signed({14'd0, cfg.yaw_gain});
			pprod_s2 <= 34'(ey_s1) * $signed({14'd0, cfg.pitch_gain});
		end
		if (load) begin
			yaw_command     <= cbt_pkg::sat32(yaw_sum);
			pitch_command   <= cbt_pkg::sat32(pitch_sum);
			target_range_mm <= range_q;
			range_valid     <= seen_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ sv/color_blob_tracking_gimbal_update.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_blob_tracking_gimbal_update
// HSV colour blob tracker producing integrated yaw and pitch commands.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on in_valid/in_stall: raster pixels, manual commands and
// range samples. Results leave on out_valid/out_stall, one for each frame
// end that tracked a target. Registers are written on cfg_valid/cfg_ready
// (always ready); the user must write them only while the block is idle,
// which the block itself does not enforce. A pixel that may match goes
// through the two serial dividers computing the saturation and hue scale
// (one bit a cycle), then a multiply and an evaluate state; other pixels
// go straight to evaluation, and manual and range requests are handled
// when accepted. A tracked frame end is divided in the back part,
// overlapped with further pixels through a two-entry job queue, then
// multiplied by the gains and saturated before the result is registered.
// Reset clears the registers to their defaults, the accumulators and the
// command integrators but not the outputs. A stalled result holds; the
// back part waits for it; once the queue is full the input stalls too.
// ----------------------------------------------------------------------------
module color_blob_tracking_gimbal_update (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [22:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          func,
	input  logic [7:0]          blue,
	input  logic [7:0]          green,
	input  logic [7:0]          red,
	input  logic                end_of_frame,
	input  logic signed [31:0]  manual_yaw,
	input  logic signed [31:0]  manual_pitch,
	input  logic [15:0]         range_mm,
	input  logic                range_ok,
	input  logic [15:0]         range_min_mm,
	input  logic [15:0]         range_max_mm,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  yaw_command,
	output logic signed [31:0]  pitch_command,
	output logic [15:0]         target_range_mm,
	output logic                range_valid
);

	cbt_pkg::cfg_t cfg_q;
	cbt_pkg::job_t push_job;
	cbt_pkg::job_t head;
	logic          q_push;
	logic          q_pop;
	logic          q_empty;
	logic          q_full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_mode     <= cbt_pkg::MODE_NONE;
			cfg_q.frame_width     <= 12'd640;
			cfg_q.frame_height    <= 12'd480;
			cfg_q.deadzone_pixels <= 11'd20;
			cfg_q.yaw_gain        <= 20'd524;
			cfg_q.pitch_gain      <= 20'd262;
			cfg_q.min_count       <= 23'd3;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cbt_pkg::REG_TARGET_MODE:  cfg_q.target_mode     <= cfg_data[1:0];
				cbt_pkg::REG_FRAME_WIDTH:  cfg_q.frame_width     <= cfg_data[11:0];
				cbt_pkg::REG_FRAME_HEIGHT: cfg_q.frame_height    <= cfg_data[11:0];
				cbt_pkg::REG_DEADZONE:     cfg_q.deadzone_pixels <= cfg_data[10:0];
				cbt_pkg::REG_YAW_GAIN:     cfg_q.yaw_gain        <= cfg_data[19:0];
				cbt_pkg::REG_PITCH_GAIN:   cfg_q.pitch_gain      <= cfg_data[19:0];
				cbt_pkg::REG_MIN_COUNT:    cfg_q.min_count       <= cfg_data[22:0];
				default: ;
			endcase
		end
	end

	cbt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.blue         (blue),
		.green        (green),
		.red          (red),
		.end_of_frame (end_of_frame),
		.manual_yaw   (manual_yaw),
		.manual_pitch (manual_pitch),
		.range_mm     (range_mm),
		.range_ok     (range_ok),
		.range_min_mm (range_min_mm),
		.range_max_mm (range_max_mm),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_job        (push_job)
	);

	cbt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	cbt_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.head            (head),
		.q_empty         (q_empty),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.yaw_command     (yaw_command),
		.pitch_command   (pitch_command),
		.target_range_mm (target_range_mm),
		.range_valid     (range_valid)
	);

endmodule
